FILE: hdl/yuv2rgb_pkg.sv
package yuv2rgb_pkg;

   localparam int PIX_W   = 8;
   localparam int COEF_W  = 11;
   localparam int YOFF_W  = PIX_W + 1;
   localparam int PROD_W  = 20;
   localparam int CSR_W   = 1;
   localparam int CSR_IDX_W = 1;
   localparam int RND_SHIFT = 8;
   localparam int CHAN_W  = PROD_W - RND_SHIFT;

   localparam logic [PIX_W-1:0]  CHROMA_ZERO = 8'd128;
   localparam logic [PIX_W-1:0]  ALPHA_OPAQUE = 8'hFF;
   localparam logic [PIX_W-1:0]  CHAN_MAX = 8'hFF;
   localparam logic signed [PROD_W-1:0] RND_BIAS = 20'sd128;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FULL_SWING = 1'b0,
      CSR_MATRIX_709 = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] ys;
      logic [PIX_W-1:0]         ysub;
      logic signed [COEF_W-1:0] kr;
      logic signed [COEF_W-1:0] kgu;
      logic signed [COEF_W-1:0] kgv;
      logic signed [COEF_W-1:0] kb;
   } coef_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] y;
      logic signed [PROD_W-1:0] r;
      logic signed [PROD_W-1:0] gu;
      logic signed [PROD_W-1:0] gv;
      logic signed [PROD_W-1:0] b;
   } prod_type;

   function automatic coef_type coef_lookup(input logic full_swing, input logic matrix_709);
      coef_type c;
      case ({full_swing, matrix_709})
         2'b00: c = '{11'sd298, 8'd16, 11'sd409, -11'sd100, -11'sd208, 11'sd516};
         2'b01: c = '{11'sd298, 8'd16, 11'sd459, -11'sd55,  -11'sd136, 11'sd541};
         2'b10: c = '{11'sd256, 8'd0,  11'sd359, -11'sd88,  -11'sd183, 11'sd454};
         default: c = '{11'sd256, 8'd0, 11'sd403, -11'sd48, -11'sd120, 11'sd475};
      endcase
      return c;
   endfunction

endpackage

FILE: hdl/yuv_to_rgba_color_convert.sv
// YCbCr to RGBA pixel converter. One pixel per clock is accepted while req_ready is
// high; its RGBA beat passes offset removal, multiply, channel sum, then round, shift
// and clamp, each in its own register stage with per-stage valid, so a stalled output
// only back-pressures as far as the first empty stage. csr index 0 is full_swing (reset
// 0, limited range), index 1 is matrix_709 (reset 1); write them only while no beat is
// in flight. Alpha is always 0xFF.
module yuv_to_rgba_color_convert (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [yuv2rgb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [yuv2rgb_pkg::CSR_W-1:0]    csr_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [yuv2rgb_pkg::PIX_W-1:0]    req_luma,
   input  logic [yuv2rgb_pkg::PIX_W-1:0]    req_chroma_blue,
   input  logic [yuv2rgb_pkg::PIX_W-1:0]    req_chroma_red,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [yuv2rgb_pkg::PIX_W-1:0]    rsp_red,
   output logic [yuv2rgb_pkg::PIX_W-1:0]    rsp_green,
   output logic [yuv2rgb_pkg::PIX_W-1:0]    rsp_blue,
   output logic [yuv2rgb_pkg::PIX_W-1:0]    rsp_alpha
);
   import yuv2rgb_pkg::*;

   coef_type coef;
   prod_type prod;
   logic     mid_valid;
   logic     mid_ready;

   yuv2rgb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coef      (coef)
   );

   yuv2rgb_mul u_mul (
      .clock       (clock),
      .reset       (reset),
      .coef        (coef),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .luma        (req_luma),
      .chroma_blue (req_chroma_blue),
      .chroma_red  (req_chroma_red),
      .out_valid   (mid_valid),
      .out_ready   (mid_ready),
      .prod        (prod)
   );

   yuv2rgb_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .prod      (prod),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .red       (rsp_red),
      .green     (rsp_green),
      .blue      (rsp_blue)
   );

   assign rsp_alpha = ALPHA_OPAQUE;

   // pipeline is empty after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input back-pressure only when every stage is full and the output stalls
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready && mid_valid && !mid_ready))
      else $error("req_ready low with a free stage");

   // a stalled beat between the halves is not dropped
   assert property (@(posedge clock) disable iff (reset)
      (mid_valid && !mid_ready) |=> mid_valid)
      else $error("mid beat lost under stall");

endmodule

FILE: hdl/yuv2rgb_csr.sv
module yuv2rgb_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [yuv2rgb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [yuv2rgb_pkg::CSR_W-1:0]    csr_data,
   output yuv2rgb_pkg::coef_type            coef
);
   import yuv2rgb_pkg::*;

   logic full_swing_ff, full_swing_in;
   logic matrix_709_ff, matrix_709_in;

   always_comb begin
      full_swing_in = full_swing_ff;
      matrix_709_in = matrix_709_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FULL_SWING: full_swing_in = csr_data[0];
            CSR_MATRIX_709: matrix_709_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_swing_ff <= 1'b0;
         matrix_709_ff <= 1'b1;
      end else begin
         full_swing_ff <= full_swing_in;
         matrix_709_ff <= matrix_709_in;
      end
   end

   assign coef = coef_lookup(full_swing_ff, matrix_709_ff);

endmodule

FILE: hdl/yuv2rgb_mul.sv
module yuv2rgb_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  yuv2rgb_pkg::coef_type        coef,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [yuv2rgb_pkg::PIX_W-1:0] luma,
   input  logic [yuv2rgb_pkg::PIX_W-1:0] chroma_blue,
   input  logic [yuv2rgb_pkg::PIX_W-1:0] chroma_red,
   output logic                         out_valid,
   input  logic                         out_ready,
   output yuv2rgb_pkg::prod_type        prod
);
   import yuv2rgb_pkg::*;

   // stage 1: offsets removed, coefficients latched
   logic                      s1_valid_ff;
   logic signed [YOFF_W-1:0]  yoff_ff, yoff_in;
   logic signed [PIX_W-1:0]   d_ff, d_in;
   logic signed [PIX_W-1:0]   e_ff, e_in;
   coef_type                  coef_ff;
   logic                      s1_ready;

   // stage 2: products
   logic                      s2_valid_ff;
   prod_type                  prod_ff, prod_in;
   logic                      s2_ready;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      yoff_in = $signed({1'b0, luma}) - $signed({1'b0, coef.ysub});
      d_in    = $signed(chroma_blue - CHROMA_ZERO);
      e_in    = $signed(chroma_red - CHROMA_ZERO);
   end

   always_comb begin
      prod_in.y  = PROD_W'(yoff_ff) * PROD_W'(coef_ff.ys);
      prod_in.r  = PROD_W'(e_ff) * PROD_W'(coef_ff.kr);
      prod_in.gu = PROD_W'(d_ff) * PROD_W'(coef_ff.kgu);
      prod_in.gv = PROD_W'(e_ff) * PROD_W'(coef_ff.kgv);
      prod_in.b  = PROD_W'(d_ff) * PROD_W'(coef_ff.kb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s1_ready) begin
         yoff_ff <= yoff_in;
         d_ff    <= d_in;
         e_ff    <= e_in;
         coef_ff <= coef;
      end
      if (s1_valid_ff && s2_ready) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign prod      = prod_ff;

endmodule

FILE: hdl/yuv2rgb_sat.sv
module yuv2rgb_sat (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  yuv2rgb_pkg::prod_type         prod,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [yuv2rgb_pkg::PIX_W-1:0] red,
   output logic [yuv2rgb_pkg::PIX_W-1:0] green,
   output logic [yuv2rgb_pkg::PIX_W-1:0] blue
);
   import yuv2rgb_pkg::*;

   function automatic logic [PIX_W-1:0] finish(input logic signed [PROD_W-1:0] sum);
      logic signed [PROD_W-1:0] biased;
      logic signed [CHAN_W-1:0] shifted;
      biased  = sum + RND_BIAS;
      shifted = CHAN_W'(biased >>> RND_SHIFT);
      if (shifted < 0)
         return '0;
      else if (shifted > $signed({{(CHAN_W-PIX_W){1'b0}}, CHAN_MAX}))
         return CHAN_MAX;
      else
         return shifted[PIX_W-1:0];
   endfunction

   // stage 3: channel sums
   logic                     s3_valid_ff;
   logic signed [PROD_W-1:0] sum_r_ff, sum_r_in;
   logic signed [PROD_W-1:0] sum_g_ff, sum_g_in;
   logic signed [PROD_W-1:0] sum_b_ff, sum_b_in;
   logic                     s3_ready;

   // stage 4: rounded, clamped beat
   logic                     s4_valid_ff;
   logic [PIX_W-1:0]         red_ff, green_ff, blue_ff;
   logic                     s4_ready;

   assign s4_ready = !s4_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign in_ready = s3_ready;

   always_comb begin
      sum_r_in = prod.y + prod.r;
      sum_g_in = prod.y + prod.gu + prod.gv;
      sum_b_in = prod.y + prod.b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s3_ready) s3_valid_ff <= in_valid;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s3_ready) begin
         sum_r_ff <= sum_r_in;
         sum_g_ff <= sum_g_in;
         sum_b_ff <= sum_b_in;
      end
      if (s3_valid_ff && s4_ready) begin
         red_ff   <= finish(sum_r_ff);
         green_ff <= finish(sum_g_ff);
         blue_ff  <= finish(sum_b_ff);
      end
   end

   assign out_valid = s4_valid_ff;
   assign red       = red_ff;
   assign green     = green_ff;
   assign blue      = blue_ff;

endmodule

FILE: bench/yuv_to_rgba_color_convert_tb.sv
`timescale 1ns / 100ps

module yuv_to_rgba_color_convert_tb;

   import yuv2rgb_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] alpha;
   } rgba_pixel_type;

   localparam bit [1:0] MODE_LIM_601  = 2'b00;
   localparam bit [1:0] MODE_LIM_709  = 2'b01;
   localparam bit [1:0] MODE_FULL_601 = 2'b10;
   localparam bit [1:0] MODE_FULL_709 = 2'b11;

   localparam int CORNER_COUNT = 6;
   localparam int RANDOM_CHUNKS = 6;
   localparam int CHUNK_PIXELS = 61;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_data;
   logic req_valid;
   logic req_ready;
   logic [PIX_W-1:0] req_luma;
   logic [PIX_W-1:0] req_chroma_blue;
   logic [PIX_W-1:0] req_chroma_red;
   logic rsp_valid;
   logic rsp_ready;
   logic [PIX_W-1:0] rsp_red;
   logic [PIX_W-1:0] rsp_green;
   logic [PIX_W-1:0] rsp_blue;
   logic [PIX_W-1:0] rsp_alpha;

   rgba_pixel_type expected_rgba[$];
   bit mode_full_swing;
   bit mode_matrix_709;
   int send_idle_pct;
   int recv_idle_pct;
   int error_count;

   // luma, Cb, Cr
   logic [PIX_W-1:0] corner_pix [CORNER_COUNT][3] = '{
      '{8'd0,   8'd0,   8'd0},
      '{8'd255, 8'd255, 8'd255},
      '{8'd8,   8'd128, 8'd128},
      '{8'd255, 8'd0,   8'd255},
      '{8'd0,   8'd255, 8'd0},
      '{8'd235, 8'd128, 8'd128}
   };

   yuv_to_rgba_color_convert DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_luma        (req_luma),
      .req_chroma_blue (req_chroma_blue),
      .req_chroma_red  (req_chroma_red),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_alpha       (rsp_alpha)
   );

   always #5 clock = ~clock;

   function automatic logic [PIX_W-1:0] saturate_channel(input int sum);
      int v;
      v = (sum + 128) >>> 8;
      if (v < 0) return '0;
      if (v > 255) return 8'd255;
      return v[PIX_W-1:0];
   endfunction

   function automatic rgba_pixel_type predict_rgba(input logic [PIX_W-1:0] y,
                                                   input logic [PIX_W-1:0] cb,
                                                   input logic [PIX_W-1:0] cr,
                                                   input bit fr, input bit m709);
      rgba_pixel_type p;
      int ys, yoff, kr, kgu, kgv, kb;
      int luma_term, d, e;
      case ({fr, m709})
         MODE_LIM_601: begin
            ys = 298; yoff = 16; kr = 409; kgu = -100; kgv = -208; kb = 516;
         end
         MODE_LIM_709: begin
            ys = 298; yoff = 16; kr = 459; kgu = -55; kgv = -136; kb = 541;
         end
         MODE_FULL_601: begin
            ys = 256; yoff = 0; kr = 359; kgu = -88; kgv = -183; kb = 454;
         end
         default: begin
            ys = 256; yoff = 0; kr = 403; kgu = -48; kgv = -120; kb = 475;
         end
      endcase
      luma_term = (int'(y) - yoff) * ys;
      d = int'(cb) - 128;
      e = int'(cr) - 128;
      p.red   = saturate_channel(luma_term + kr * e);
      p.green = saturate_channel(luma_term + kgu * d + kgv * e);
      p.blue  = saturate_channel(luma_term + kb * d);
      p.alpha = ALPHA_OPAQUE;
      return p;
   endfunction

   // called at a falling edge; leaves valid high on return
   task automatic send_pixel(input logic [PIX_W-1:0] y, input logic [PIX_W-1:0] cb,
                             input logic [PIX_W-1:0] cr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_luma        <= y;
      req_chroma_blue <= cb;
      req_chroma_red  <= cr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rgba.push_back(predict_rgba(y, cb, cr, mode_full_swing, mode_matrix_709));
      @(negedge clock);
   endtask

   task automatic wait_pixels_drained;
      req_valid <= 1'b0;
      while (expected_rgba.size() != 0) @(negedge clock);
   endtask

   task automatic set_conversion_mode(input bit fr, input bit m709);
      csr_we    <= 1'b1;
      csr_index <= CSR_FULL_SWING;
      csr_data  <= fr;
      @(negedge clock);
      csr_index <= CSR_MATRIX_709;
      csr_data  <= m709;
      @(negedge clock);
      csr_we <= 1'b0;
      mode_full_swing = fr;
      mode_matrix_709 = m709;
   endtask

   task automatic send_corner_pixels;
      for (int i = 0; i < CORNER_COUNT; i++)
         send_pixel(corner_pix[i][0], corner_pix[i][1], corner_pix[i][2]);
   endtask

   function automatic logic [PIX_W-1:0] random_sample;
      case ($urandom_range(3))
         0: return PIX_W'($urandom_range(15));
         1: return PIX_W'(240 + $urandom_range(15));
         default: return PIX_W'($urandom_range(255));
      endcase
   endfunction

   // limited range with BT.709 straight out of reset
   task automatic test_reset_mode;
      send_corner_pixels();
      wait_pixels_drained();
   endtask

   task automatic test_mode_extremes;
      bit [1:0] modes [3] = '{MODE_FULL_709, MODE_FULL_601, MODE_LIM_601};
      for (int m = 0; m < 3; m++) begin
         set_conversion_mode(modes[m][1], modes[m][0]);
         send_corner_pixels();
         wait_pixels_drained();
      end
   endtask

   task automatic test_random_pixels(input int snd_pct, input int rcv_pct);
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      for (int c = 0; c < RANDOM_CHUNKS; c++) begin
         set_conversion_mode(1'($urandom_range(1)), 1'($urandom_range(1)));
         for (int i = 0; i < CHUNK_PIXELS; i++)
            send_pixel(random_sample(), random_sample(), random_sample());
         wait_pixels_drained();
      end
   endtask

   task automatic check_field(input string name, input logic [PIX_W-1:0] want,
                              input logic [PIX_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin : rsp_check
      rgba_pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rgba.size() == 0) begin
            $error("unexpected beat: red %0d green %0d blue %0d alpha %0d",
                   rsp_red, rsp_green, rsp_blue, rsp_alpha);
            error_count++;
         end else begin
            want = expected_rgba.pop_front();
            check_field("red", want.red, rsp_red);
            check_field("green", want.green, rsp_green);
            check_field("blue", want.blue, rsp_blue);
            check_field("alpha", want.alpha, rsp_alpha);
         end
      end
   end

   initial begin
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = CSR_FULL_SWING;
      csr_data        = '0;
      req_valid       = 1'b0;
      req_luma        = '0;
      req_chroma_blue = '0;
      req_chroma_red  = '0;
      rsp_ready       = 1'b0;
      send_idle_pct   = 0;
      recv_idle_pct   = 0;
      error_count     = 0;
      mode_full_swing = 1'b0;
      mode_matrix_709 = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_mode();
      test_mode_extremes();
      test_random_pixels(14, 82);
      test_random_pixels(82, 14);
      test_random_pixels(0, 0);

      wait_pixels_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_rgba.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

FILE: yuv_to_rgba_color_convert.f
hdl/yuv2rgb_pkg.sv
hdl/yuv2rgb_csr.sv
hdl/yuv2rgb_mul.sv
hdl/yuv2rgb_sat.sv
hdl/yuv_to_rgba_color_convert.sv
bench/yuv_to_rgba_color_convert_tb.sv
